>>> rtl/psc_pkg.sv
// Shared constants, types and state codes of the periodic slot conflict checker.
package psc_pkg;

    localparam int TIME_SLOTS = 1048576;

    localparam int START_W  = 20;
    localparam int FINISH_W = 21;
    localparam int PERIOD_W = 21;

    localparam int SLOT_W = $clog2(TIME_SLOTS);
    localparam int CUR_W  = ((SLOT_W > PERIOD_W) ? SLOT_W : PERIOD_W) + 1;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int OCC_WORDS = (TIME_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;

    localparam int EPOCH_W = 8;
    localparam int MEM_W   = EPOCH_W + WORD_BITS;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CUR_W:0]   SLOTS_EXT = (CUR_W + 1)'(TIME_SLOTS);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(OCC_WORDS - 1);

    typedef struct packed {
        logic [CUR_W-1:0]    start;
        logic [FINISH_W-1:0] len;
        logic [PERIOD_W-1:0] period;
        logic                last;
        logic                skip;
    } t_task;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_DONE
    } t_state;

endpackage

>>> rtl/psc_front.sv
// Front stage: takes tasks from the command port and classifies them.
module psc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [psc_pkg::START_W-1:0]    i_start_req,
    input  logic [psc_pkg::FINISH_W-1:0]   i_finish,
    input  logic [psc_pkg::PERIOD_W-1:0]   i_period,
    input  logic                           i_last_of_set,
    input  logic                           i_q_full,
    output logic                           o_busy,
    output logic                           o_push,
    output psc_pkg::t_task                 o_task
);

    logic           r_valid;
    psc_pkg::t_task r_task;
    psc_pkg::t_task n_task;
    logic           accept;
    logic [psc_pkg::FINISH_W-1:0] start_ext;

    assign o_push = r_valid && !i_q_full;
    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_task = r_task;

    // A task whose range is empty stays empty in every repeat, so it marks nothing.
    always_comb begin
        start_ext     = psc_pkg::FINISH_W'(i_start_req);
        n_task.start  = psc_pkg::CUR_W'(i_start_req);
        n_task.len    = i_finish - start_ext;
        n_task.period = i_period;
        n_task.last   = i_last_of_set;
        n_task.skip   = (i_finish <= start_ext)
                     || ({1'b0, n_task.start} >= psc_pkg::SLOTS_EXT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_task <= n_task;
        end
    end

endmodule

>>> rtl/psc_fifo.sv
// Short task queue between the front and back stages.
module psc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psc_pkg::t_task i_task,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output psc_pkg::t_task o_task
);

    psc_pkg::t_task                r_slot [psc_pkg::QDEPTH];
    logic [psc_pkg::QPTR_W-1:0]    r_wptr;
    logic [psc_pkg::QPTR_W-1:0]    r_rptr;
    logic [psc_pkg::QCNT_W-1:0]    r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == psc_pkg::QCNT_W'(psc_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_task  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_task;
        end
    end

endmodule

>>> rtl/psc_back.sv
// Back stage: walks each task's slot words in the occupancy memory and reports verdicts.
module psc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  psc_pkg::t_task        i_task,
    output logic                  o_pop,
    output psc_pkg::t_back_stat   o_stat,
    output logic                  o_valid,
    output logic                  o_conflict
);

    // Each word carries the epoch of the set that last wrote it; a stale epoch reads as empty.
    logic [psc_pkg::MEM_W-1:0]     r_mem [psc_pkg::OCC_WORDS];
    logic [psc_pkg::MEM_W-1:0]     r_rdata;

    psc_pkg::t_state               r_state;
    psc_pkg::t_state               n_state;

    logic [psc_pkg::CUR_W-1:0]     r_s;
    logic [psc_pkg::FINISH_W-1:0]  r_len;
    logic [psc_pkg::PERIOD_W-1:0]  r_p;
    logic                          r_last;
    logic                          r_skip;
    logic                          r_conf;
    logic [psc_pkg::EPOCH_W-1:0]   r_epoch;
    logic [psc_pkg::WADDR_W-1:0]   r_clr;
    logic [psc_pkg::WADDR_W-1:0]   r_w;
    logic [psc_pkg::WADDR_W-1:0]   r_last_w;
    logic [psc_pkg::BIT_W-1:0]     r_lo_bit;
    logic [psc_pkg::BIT_W-1:0]     r_hi_bit;
    logic                          r_is_first;

    logic [psc_pkg::CUR_W:0]       hi_raw;
    logic [psc_pkg::CUR_W:0]       hi;
    logic [psc_pkg::CUR_W:0]       hi_m1;
    logic                          range_none;
    logic [psc_pkg::WORD_BITS-1:0] cur_word;
    logic [psc_pkg::WORD_BITS-1:0] mask;
    logic                          hit;
    logic                          word_last;

    logic                          rd_en;
    logic                          wr_en;
    logic [psc_pkg::WADDR_W-1:0]   wr_addr;
    logic [psc_pkg::MEM_W-1:0]     wr_data;

    // Range setup for the current repeat, clipped at the end of the time line.
    always_comb begin
        hi_raw     = {1'b0, r_s} + (psc_pkg::CUR_W + 1)'(r_len);
        hi         = (hi_raw > psc_pkg::SLOTS_EXT) ? psc_pkg::SLOTS_EXT : hi_raw;
        hi_m1      = hi - 1'b1;
        range_none = r_skip || r_conf || ({1'b0, r_s} >= psc_pkg::SLOTS_EXT);
    end

    // Merge of one memory word with the mask of the range.
    always_comb begin
        word_last = (r_w == r_last_w);
        if (r_rdata[psc_pkg::MEM_W-1 -: psc_pkg::EPOCH_W] == r_epoch) begin
            cur_word = r_rdata[psc_pkg::WORD_BITS-1:0];
        end else begin
            cur_word = '0;
        end
        mask = '1;
        if (r_is_first) begin
            mask = mask & ({psc_pkg::WORD_BITS{1'b1}} << r_lo_bit);
        end
        if (word_last) begin
            mask = mask & ({psc_pkg::WORD_BITS{1'b1}} >> (6'd63 - r_hi_bit));
        end
        hit = |(cur_word & mask);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            psc_pkg::ST_CLEAR: begin
                if (r_clr == psc_pkg::LAST_WORD) begin
                    n_state = psc_pkg::ST_IDLE;
                end
            end
            psc_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = psc_pkg::ST_SETUP;
                end
            end
            psc_pkg::ST_SETUP: begin
                n_state = range_none ? psc_pkg::ST_DONE : psc_pkg::ST_RD;
            end
            psc_pkg::ST_RD: begin
                n_state = psc_pkg::ST_WR;
            end
            psc_pkg::ST_WR: begin
                if (hit) begin
                    n_state = psc_pkg::ST_DONE;
                end else if (!word_last) begin
                    n_state = psc_pkg::ST_RD;
                end else if (r_p == '0) begin
                    n_state = psc_pkg::ST_DONE;
                end else begin
                    n_state = psc_pkg::ST_SETUP;
                end
            end
            psc_pkg::ST_DONE: begin
                if (r_last && (r_epoch == '1)) begin
                    n_state = psc_pkg::ST_CLEAR;
                end else begin
                    n_state = psc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_pop           = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = r_w;
        wr_data         = {r_epoch, cur_word | mask};
        o_valid         = 1'b0;
        o_stat.clearing = 1'b0;
        case (r_state)
            psc_pkg::ST_CLEAR: begin
                o_stat.clearing = 1'b1;
                wr_en           = 1'b1;
                wr_addr         = r_clr;
                wr_data         = '0;
            end
            psc_pkg::ST_IDLE: begin
                o_pop = !i_q_empty;
            end
            psc_pkg::ST_RD: begin
                rd_en = 1'b1;
            end
            psc_pkg::ST_WR: begin
                wr_en = 1'b1;
            end
            psc_pkg::ST_DONE: begin
                o_valid = r_last;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_conflict = r_conf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psc_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_epoch <= '0;
            r_conf  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                psc_pkg::ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                psc_pkg::ST_WR: begin
                    if (hit) begin
                        r_conf <= 1'b1;
                    end
                end
                psc_pkg::ST_DONE: begin
                    if (r_last) begin
                        r_conf  <= 1'b0;
                        r_epoch <= r_epoch + 1'b1;
                        r_clr   <= '0;
                    end
                end
                default: begin
                    r_conf <= r_conf;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            psc_pkg::ST_IDLE: begin
                r_s    <= i_task.start;
                r_len  <= i_task.len;
                r_p    <= i_task.period;
                r_last <= i_task.last;
                r_skip <= i_task.skip;
            end
            psc_pkg::ST_SETUP: begin
                r_w        <= r_s[psc_pkg::BIT_W +: psc_pkg::WADDR_W];
                r_last_w   <= hi_m1[psc_pkg::BIT_W +: psc_pkg::WADDR_W];
                r_lo_bit   <= r_s[psc_pkg::BIT_W-1:0];
                r_hi_bit   <= hi_m1[psc_pkg::BIT_W-1:0];
                r_is_first <= 1'b1;
            end
            psc_pkg::ST_WR: begin
                r_is_first <= 1'b0;
                if (!word_last) begin
                    r_w <= r_w + 1'b1;
                end else begin
                    r_s <= r_s + psc_pkg::CUR_W'(r_p);
                end
            end
            default: begin
                r_is_first <= r_is_first;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_w];
        end
    end

`ifndef SYNTH
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psc_pkg::ST_WR) |-> ($past(r_state) == psc_pkg::ST_RD))
        else $error("memory merge without a preceding read");

    a_flag_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !r_conf)
        else $error("conflict flag survives the verdict");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> ((r_state == psc_pkg::ST_IDLE) && !i_q_empty))
        else $error("task taken outside idle");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psc_pkg::ST_WR) |-> (r_w <= r_last_w))
        else $error("word walk ran past the end of its range");

    a_clear_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psc_pkg::ST_CLEAR) |-> (r_epoch == '0) && !r_conf)
        else $error("clearing pass with a live epoch");
`endif

endmodule

>>> rtl/periodic_slot_conflict_checker_top.sv
// Top level of the periodic slot conflict checker.
// A transferred task waits in the front register and then in the queue until the word
// walker pops it in idle; there it gets one range setup per repeat (plus a closing one for a
// repeating task), and each 64-slot word of a repeat is read and then merged and written back;
// the verdict strobe comes in the done state of a set's last task. The walker works on one
// task at a time; a front register and a two-entry queue hold up to three tasks.
// Reset: synchronous, active low; a clearing pass over all 16384 memory words follows reset
// and every 256th set, with busy high. The receiver cannot stall: o_valid lasts one cycle.
module periodic_slot_conflict_checker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [psc_pkg::START_W-1:0]    i_start_req,
    input  logic [psc_pkg::FINISH_W-1:0]   i_finish,
    input  logic [psc_pkg::PERIOD_W-1:0]   i_period,
    input  logic                           i_last_of_set,
    output logic                           o_valid,
    output logic                           o_conflict
);

    // Handshake between the front register and the queue.
    logic                 front_busy;
    logic                 front_push;
    psc_pkg::t_task       front_task;

    // Queue status and head entry seen by the back stage.
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    psc_pkg::t_task       q_task;

    psc_pkg::t_back_stat  back_stat;

    // No task is taken while the occupancy memory is being swept clean, so a transfer
    // on the command port always lands in a fresh epoch.
    assign busy = front_busy || back_stat.clearing;

    psc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start && !back_stat.clearing),
        .i_start_req   (i_start_req),
        .i_finish      (i_finish),
        .i_period      (i_period),
        .i_last_of_set (i_last_of_set),
        .i_q_full      (q_full),
        .o_busy        (front_busy),
        .o_push        (front_push),
        .o_task        (front_task)
    );

    psc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_task  (front_task),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_task  (q_task)
    );

    // The back stage owns the occupancy memory, the sticky conflict flag and the epoch.
    psc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_task     (q_task),
        .o_pop      (q_pop),
        .o_stat     (back_stat),
        .o_valid    (o_valid),
        .o_conflict (o_conflict)
    );

endmodule

>>> dv/periodic_slot_conflict_checker_top_test.sv
// Self-checking testbench of the periodic slot conflict checker top level.
`timescale 1ns / 1ps

module periodic_slot_conflict_checker_top_test;

    // The sender stops once this many tasks have been transferred, at the end of a set.
    localparam int TASK_TARGET = 420;
    // Cycles in a row without any transfer that count as a hang. A task may walk the whole
    // time line, and a clearing pass can come on top of it.
    localparam int QUIET_LIMIT = 200000;
    // Cycles to idle after the final verdict before the run ends.
    localparam int DRAIN_CYCLES = 64;
    localparam int SET_MAX = 5;

    // One task as it is put on the input ports.
    typedef struct {
        logic [psc_pkg::START_W-1:0]  first_slot;
        logic [psc_pkg::FINISH_W-1:0] end_slot;
        logic [psc_pkg::PERIOD_W-1:0] repeat_gap;
        logic                         ends_set;
    } t_slot_req;

    // Keeps its own occupancy bitmap and sticky flag, works out the verdict of each set
    // as its tasks are transferred, and checks the verdicts the block reports in order.
    class t_slot_scoreboard;
        bit [63:0] occ_words[];
        bit        conflict_flag;
        bit        verdict_q[$];
        int        errors;
        int        tasks_noted;
        int        verdicts_checked;
        int        conflicts_reported;

        function new();
            occ_words = new[psc_pkg::OCC_WORDS];
        endfunction

        // Marks slots [lo, hi); tells whether any of them was taken already.
        function bit mark_span(longint unsigned lo, longint unsigned hi);
            longint unsigned first_w;
            longint unsigned last_w;
            longint unsigned tail;
            longint unsigned w;
            bit [63:0]       m;
            bit              hit;
            tail    = hi - 1;
            first_w = lo >> 6;
            last_w  = tail >> 6;
            hit     = 1'b0;
            for (w = first_w; w <= last_w && w < psc_pkg::OCC_WORDS; w++) begin
                m = ~64'd0;
                if (w == first_w) m &= ~64'd0 << lo[5:0];
                if (w == last_w) m &= ~64'd0 >> (6'd63 - tail[5:0]);
                if ((occ_words[w] & m) != 64'd0) hit = 1'b1;
                occ_words[w] |= m;
            end
            return hit;
        endfunction

        function void note_task(t_slot_req r);
            longint unsigned s;
            longint unsigned f;
            longint unsigned p;
            longint unsigned e;
            longint unsigned slots;
            slots = psc_pkg::TIME_SLOTS;
            s = r.first_slot;
            f = r.end_slot;
            p = r.repeat_gap;
            tasks_noted++;
            // Each repeat is clipped at the end of the line; once the set has a
            // conflict, nothing more can change its verdict.
            while (s < slots && !conflict_flag) begin
                e = (f < slots) ? f : slots;
                if (s < e && mark_span(s, e)) conflict_flag = 1'b1;
                if (p == 0) break;
                s += p;
                f += p;
            end
            if (r.ends_set) begin
                verdict_q.push_back(conflict_flag);
                conflict_flag = 1'b0;
                foreach (occ_words[i]) occ_words[i] = 64'd0;
            end
        endfunction

        function void check_verdict(logic actual);
            bit wanted;
            verdicts_checked++;
            if (actual === 1'b1) conflicts_reported++;
            if (verdict_q.size() == 0) begin
                $error("conflict: no verdict expected, actual %0b", actual);
                errors++;
            end else begin
                wanted = verdict_q.pop_front();
                if (actual !== wanted) begin
                    $error("conflict: expected %0b, actual %0b", wanted, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [psc_pkg::START_W-1:0]  i_start_req;
    logic [psc_pkg::FINISH_W-1:0] i_finish;
    logic [psc_pkg::PERIOD_W-1:0] i_period;
    logic                         i_last_of_set;
    logic                         o_valid;
    logic                         o_conflict;

    t_slot_scoreboard sb;
    int               quiet_cycles;
    int               burst_left;
    int               tasks_sent;
    int               sets_sent;

    periodic_slot_conflict_checker_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_req   (i_start_req),
        .i_finish      (i_finish),
        .i_period      (i_period),
        .i_last_of_set (i_last_of_set),
        .o_valid       (o_valid),
        .o_conflict    (o_conflict)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Observation at each rising edge. The block and the driver both update with
    // nonblocking assignments, so this block sees the values that held during the
    // cycle the edge closes: a task transfers when start was high and busy low, and
    // a verdict transfers when o_valid was high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (start && !busy) begin
                t_slot_req seen;
                seen.first_slot = i_start_req;
                seen.end_slot   = i_finish;
                seen.repeat_gap = i_period;
                seen.ends_set   = i_last_of_set;
                sb.note_task(seen);
            end
            if (o_valid) sb.check_verdict(o_conflict);
            quiet_cycles <= ((start && !busy) || o_valid) ? 0 : quiet_cycles + 1;
        end
    end

    // A hang shows as a long stretch with no transfer on either side.
    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Puts one task on the ports and holds it until the block takes it. Afterwards the
    // sender either goes straight on with the next task of its burst or, at the end of a
    // burst, drops start for a random gap. Some bursts end with no gap at all, so there
    // are long stretches where start never falls.
    task automatic send_task(input t_slot_req r);
        int gap;
        start         <= 1'b1;
        i_start_req   <= r.first_slot;
        i_finish      <= r.end_slot;
        i_period      <= r.repeat_gap;
        i_last_of_set <= r.ends_set;
        do @(posedge i_clk); while (busy);
        tasks_sent++;
        if (r.ends_set) sets_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Builds one task from its fields.
    function automatic t_slot_req mk(longint unsigned s, longint unsigned f,
                                     longint unsigned p, bit l);
        t_slot_req r;
        r.first_slot = psc_pkg::START_W'(s);
        r.end_slot   = psc_pkg::FINISH_W'(f);
        r.repeat_gap = psc_pkg::PERIOD_W'(p);
        r.ends_set   = l;
        return r;
    endfunction

    initial begin : stimulus
        t_slot_req       set_reqs[SET_MAX];
        t_slot_req       r;
        int              n_in_set;
        int              mode;
        longint unsigned base;
        longint unsigned len;
        longint unsigned slots;

        slots         = psc_pkg::TIME_SLOTS;
        sb            = new();
        burst_left    = 0;
        tasks_sent    = 0;
        sets_sent     = 0;
        start         <= 1'b0;
        i_start_req   <= '0;
        i_finish      <= '0;
        i_period      <= '0;
        i_last_of_set <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets. Adjacent half-open ranges do not touch each other.
        send_task(mk(0, 64, 0, 0));
        send_task(mk(64, 128, 0, 1));
        // A single shared slot right at a range end is a conflict.
        send_task(mk(100, 200, 0, 0));
        send_task(mk(199, 300, 0, 1));
        // Empty ranges, with finish equal to start and below it, mark nothing.
        send_task(mk(5, 5, 0, 0));
        send_task(mk(500, 10, 0, 0));
        send_task(mk(0, 1, 0, 1));
        // Fields at their maximum: the range is clipped to the last slot of the line
        // and the huge period never repeats; the next task hits that last slot.
        send_task(mk(slots - 1, 2097151, 2097151, 0));
        send_task(mk(slots - 1, slots, 0, 1));
        // The whole time line at once.
        send_task(mk(0, slots, 0, 1));
        // Repeats closer together than the range collide with each other.
        send_task(mk(1000, 1100, 50, 1));
        // A task repeating up to the end of the line, one that sits between its
        // repeats, and one that lands on its final repeat.
        send_task(mk(slots - 8576, slots - 8566, 100, 0));
        send_task(mk(slots - 8526, slots - 8516, 0, 0));
        send_task(mk(slots - 71, slots - 70, 0, 1));
        // Once a conflict is seen the verdict stays set for the rest of the set.
        send_task(mk(0, 10, 0, 0));
        send_task(mk(5, 15, 0, 0));
        send_task(mk(20, 30, 0, 1));
        // The bitmap must be clean again for the next set.
        send_task(mk(20, 30, 0, 1));
        // Word boundary neighbors, and a period of exactly the line length.
        send_task(mk(63, 64, 0, 0));
        send_task(mk(64, 65, 1048576, 0));
        send_task(mk(10, 20, 1048576, 1));

        // Random sets. Most tasks of a set fall into one 4k-slot window so that they
        // overlap often; the rest are empty ranges, dense repeats near the end of the
        // line, fully random fields, and copies of an earlier task of the set.
        // The windowed tasks get no period or a long one and the dense repeats start high, so that
        // their repeat count and with it the time per task stays small.
        while (tasks_sent < TASK_TARGET) begin
            n_in_set = $urandom_range(1, SET_MAX);
            base     = $urandom_range(0, psc_pkg::TIME_SLOTS - 1);
            for (int i = 0; i < n_in_set; i++) begin
                mode = $urandom_range(0, 99);
                if (mode < 60 || (mode >= 88 && i == 0)) begin
                    len = $urandom_range(1, 256);
                    r.first_slot = psc_pkg::START_W'(base + $urandom_range(0, 4095));
                    r.end_slot   = psc_pkg::FINISH_W'(longint'(r.first_slot) + len);
                    r.repeat_gap = ($urandom_range(0, 9) < 4) ? '0 :
                                   psc_pkg::PERIOD_W'($urandom_range(65536, 2097151));
                end else if (mode < 70) begin
                    r.first_slot = psc_pkg::START_W'($urandom);
                    r.end_slot   = psc_pkg::FINISH_W'($urandom_range(0, r.first_slot));
                    r.repeat_gap = psc_pkg::PERIOD_W'($urandom);
                end else if (mode < 80) begin
                    len = $urandom_range(1, 600);
                    r.first_slot = psc_pkg::START_W'(
                        $urandom_range(psc_pkg::TIME_SLOTS - 65536, psc_pkg::TIME_SLOTS - 1));
                    r.end_slot   = psc_pkg::FINISH_W'(longint'(r.first_slot) + len);
                    r.repeat_gap = psc_pkg::PERIOD_W'($urandom_range(256, 4095));
                end else if (mode < 88) begin
                    r.first_slot = psc_pkg::START_W'($urandom);
                    r.end_slot   = psc_pkg::FINISH_W'($urandom);
                    r.repeat_gap = psc_pkg::PERIOD_W'($urandom);
                end else begin
                    r = set_reqs[$urandom_range(0, i - 1)];
                end
                r.ends_set  = (i == n_in_set - 1);
                set_reqs[i] = r;
                send_task(r);
            end
        end
        start <= 1'b0;

        // Every set ended with a verdict request; wait for the last verdict, then let
        // the block settle. The watchdog catches a verdict that never comes.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d tasks in %0d sets through the checker, directed corner cases first.",
                 tasks_sent, sets_sent);
        $display("Checked %0d verdicts, %0d of them conflicts, with %0d mismatches.",
                 sb.verdicts_checked, sb.conflicts_reported, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_fifo.sv
rtl/psc_back.sv
rtl/periodic_slot_conflict_checker_top.sv
dv/periodic_slot_conflict_checker_top_test.sv
